[rtl/core/fbpa_pkg.sv]
package fbpa_pkg;

   localparam int POOL_DEPTH = 64;
   localparam int PTR_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_SPACE    = 2'd1;
   localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

   localparam logic [15:0] BLOCK_SIZE_RESET = 16'd256;

   typedef struct packed {
      logic       operation;
      logic [6:0] count;
      logic [5:0] block_id;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [5:0]  out_block;
      logic [21:0] base_offset;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

endpackage

[rtl/core/fifo_block_pool_allocator_unit.sv]
// Pool allocator for fixed-size blocks, built around a free-id queue memory and
// a live-bit memory, both synchronous with registered reads.
// req channel (valid/stall): operation 0 asks for count blocks, operation 1
// releases block_id. rsp channel (valid/stall): one item per granted block,
// with id and base offset (id * block size), the final one flagged last; a
// failed, empty or release request answers with a single item.
// csr channel (valid/ready): writes the block size; always ready, to be
// written only while the block is idle.
// A request of n blocks does one queue read per grant, each overlapped with the
// grant before it; a refused or empty request goes through one reply state, and
// a release waits on the live-bit read before the decision.
// Only one item is in work at a time; req_stall is high until its last result
// sits in the output register.
// Reset (synchronous, active high) restores the queue to ids in order through
// per-entry valid bits, clears all live bits at once and sets the block size
// to 256; no clearing pass is needed.
// When rsp_stall is high while an item is held, the output register holds it and
// the work pauses until it is taken.
module fifo_block_pool_allocator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fbpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fbpa_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import fbpa_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_GRANT, S_CHECK, S_REPLY} state_type;

   state_type  state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] free_ff, free_in, remain_ff, remain_in;
   logic [PTR_W-1:0] rel_id_ff, rel_id_in;
   logic             range_ok_ff, range_ok_in;
   logic [1:0]       status_ff, status_in;
   logic [15:0]      block_size_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [5:0]       free_queue [POOL_DEPTH];
   logic             live_map   [POOL_DEPTH];
   logic [POOL_DEPTH-1:0] q_valid_ff, l_valid_ff;

   logic [5:0]       q_rd_ff;
   logic             q_rdv_ff;
   logic [PTR_W-1:0] q_rda_ff;
   logic             l_rd_ff, l_rdv_ff;

   logic             q_rd_en, q_wr_en, l_rd_en, l_wr_en, l_wr_data;
   logic [PTR_W-1:0] q_rd_addr, l_rd_addr, l_wr_addr;
   logic             out_free, rsp_load, rel_ok;
   logic [5:0]       grant_id;
   logic [PTR_W-1:0] head_next;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(POOL_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign grant_id  = q_rdv_ff ? q_rd_ff : 6'(q_rda_ff);
   assign head_next = wrap_next(head_ff);
   assign rel_ok    = range_ok_ff && l_rdv_ff && l_rd_ff && (free_ff < CNT_W'(POOL_DEPTH));

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      remain_in   = remain_ff;
      rel_id_in   = rel_id_ff;
      range_ok_in = range_ok_ff;
      status_in   = status_ff;
      rsp_in      = rsp_ff;
      rsp_load    = 1'b0;
      q_rd_en     = 1'b0;
      q_rd_addr   = head_ff;
      q_wr_en     = 1'b0;
      l_rd_en     = 1'b0;
      l_rd_addr   = req_data.block_id[PTR_W-1:0];
      l_wr_en     = 1'b0;
      l_wr_addr   = grant_id[PTR_W-1:0];
      l_wr_data   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.operation == OP_RELEASE) begin
                  rel_id_in   = req_data.block_id[PTR_W-1:0];
                  range_ok_in = (7'(req_data.block_id) < 7'(POOL_DEPTH));
                  l_rd_en     = 1'b1;
                  state_in    = S_CHECK;
               end else if (req_data.count > 7'(free_ff)) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_REPLY;
               end else if (req_data.count == 7'd0) begin
                  status_in = ST_OK;
                  state_in  = S_REPLY;
               end else begin
                  remain_in = CNT_W'(req_data.count);
                  q_rd_en   = 1'b1;
                  state_in  = S_GRANT;
               end
            end
         end
         S_GRANT: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_in.granted     = 1'b1;
               rsp_in.out_block   = grant_id;
               rsp_in.base_offset = 22'(grant_id) * 22'(block_size_ff);
               rsp_in.status      = ST_OK;
               rsp_in.last        = (remain_ff == CNT_W'(1));
               l_wr_en            = 1'b1;
               head_in            = head_next;
               free_in            = free_ff - 1'b1;
               remain_in          = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  q_rd_en   = 1'b1;
                  q_rd_addr = head_next;
               end
            end
         end
         S_CHECK: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_in.granted     = 1'b0;
               rsp_in.out_block   = '0;
               rsp_in.base_offset = '0;
               rsp_in.status      = rel_ok ? ST_OK : ST_BAD_RELEASE;
               rsp_in.last        = 1'b1;
               if (rel_ok) begin
                  l_wr_en   = 1'b1;
                  l_wr_addr = rel_id_ff;
                  l_wr_data = 1'b0;
                  q_wr_en   = 1'b1;
                  tail_in   = wrap_next(tail_ff);
                  free_in   = free_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_in.granted     = 1'b0;
               rsp_in.out_block   = '0;
               rsp_in.base_offset = '0;
               rsp_in.status      = status_ff;
               rsp_in.last        = 1'b1;
               state_in           = S_IDLE;
            end
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_ff       <= CNT_W'(POOL_DEPTH);
         remain_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         block_size_ff <= BLOCK_SIZE_RESET;
         q_valid_ff    <= '0;
         l_valid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            block_size_ff <= csr_data;
         end
         if (q_wr_en) begin
            q_valid_ff[tail_ff] <= 1'b1;
         end
         if (l_wr_en) begin
            l_valid_ff[l_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rel_id_ff   <= rel_id_in;
      range_ok_ff <= range_ok_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (q_rd_en) begin
         q_rdv_ff <= q_valid_ff[q_rd_addr];
         q_rda_ff <= q_rd_addr;
      end
      if (l_rd_en) begin
         l_rdv_ff <= l_valid_ff[l_rd_addr];
      end
   end

   // free-id queue
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         free_queue[tail_ff] <= 6'(rel_id_ff);
      end
      if (q_rd_en) begin
         q_rd_ff <= free_queue[q_rd_addr];
      end
   end

   // live bits
   always_ff @(posedge clock) begin
      if (l_wr_en) begin
         live_map[l_wr_addr] <= l_wr_data;
      end
      if (l_rd_en) begin
         l_rd_ff <= live_map[l_rd_addr];
      end
   end

endmodule

[rtl/core/fbpa_checker.sv]
module fbpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input fbpa_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fbpa_pkg::rsp_type rsp_data
);
   import fbpa_pkg::*;

   // output holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken while previous item in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |->
         rsp_data.out_block == 6'd0 && rsp_data.base_offset == 22'd0 && rsp_data.last)
      else $error("ungranted rsp item carries a block");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted |-> rsp_data.status == ST_OK)
      else $error("granted rsp item with error status");

endmodule

bind fifo_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[test/fifo_block_pool_allocator_unit_tb.sv]
module fifo_block_pool_allocator_unit_tb;
   import fbpa_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int STUCK_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 60;
   localparam int REPORT_LIMIT = 10;

   // shadow of the pool: free-id ring, live bits and block size
   class pool_shadow;
      rsp_type              grants_due[$];
      logic [PTR_W-1:0]     free_ring[POOL_DEPTH];
      logic [PTR_W-1:0]     head;
      logic [PTR_W-1:0]     tail;
      logic [CNT_W-1:0]     free_cnt;
      logic [POOL_DEPTH-1:0] live;
      logic [15:0]          block_size;
      int                   failures;

      function new();
         for (int i = 0; i < POOL_DEPTH; i++) free_ring[i] = PTR_W'(i);
         head       = '0;
         tail       = '0;
         free_cnt   = CNT_W'(POOL_DEPTH);
         live       = '0;
         block_size = BLOCK_SIZE_RESET;
         failures   = 0;
      endfunction

      function void set_block_size(logic [15:0] v);
         block_size = v;
      endfunction

      function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
         return (int'(p) == POOL_DEPTH - 1) ? '0 : p + 1'b1;
      endfunction

      function void push_reply(logic granted, logic [5:0] id, logic [1:0] status, logic last);
         rsp_type      r;
         int unsigned  prod;
         prod          = granted ? int'(id) * int'(block_size) : 0;
         r.granted     = granted;
         r.out_block   = granted ? id : '0;
         r.base_offset = 22'(prod);
         r.status      = status;
         r.last        = last;
         grants_due.push_front(r);
      endfunction

      function void accept_request(req_type it);
         logic [5:0] b;
         if (it.operation == OP_REQUEST) begin
            if (it.count > free_cnt) begin
               push_reply(1'b0, '0, ST_NO_SPACE, 1'b1);
            end else if (it.count == 0) begin
               push_reply(1'b0, '0, ST_OK, 1'b1);
            end else begin
               for (int k = 0; k < int'(it.count); k++) begin
                  b        = free_ring[head];
                  head     = step_ptr(head);
                  free_cnt = free_cnt - 1'b1;
                  live[b]  = 1'b1;
                  push_reply(1'b1, b, ST_OK, k + 1 == int'(it.count));
               end
            end
         end else if (int'(it.block_id) >= POOL_DEPTH || !live[it.block_id]
                      || int'(free_cnt) >= POOL_DEPTH) begin
            push_reply(1'b0, '0, ST_BAD_RELEASE, 1'b1);
         end else begin
            live[it.block_id] = 1'b0;
            free_ring[tail]   = it.block_id;
            tail              = step_ptr(tail);
            free_cnt          = free_cnt + 1'b1;
            push_reply(1'b0, '0, ST_OK, 1'b1);
         end
      endfunction

      function void match_response(rsp_type got);
         rsp_type exp;
         if (grants_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected item: granted=%0d block=%0d offset=%0d status=%0d last=%0d",
                        got.granted, got.out_block, got.base_offset, got.status, got.last);
            return;
         end
         exp = grants_due.pop_back();
         if (got.granted !== exp.granted || got.out_block !== exp.out_block
             || got.base_offset !== exp.base_offset || got.status !== exp.status
             || got.last !== exp.last) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"mismatch: expected granted=%0d block=%0d offset=%0d status=%0d",
                         " last=%0d, got granted=%0d block=%0d offset=%0d status=%0d",
                         " last=%0d"},
                        exp.granted, exp.out_block, exp.base_offset, exp.status, exp.last,
                        got.granted, got.out_block, got.base_offset, got.status, got.last);
         end
      endfunction

      function int pending();
         return grants_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   pool_shadow  pool;
   int          send_idle_pct;
   int          stall_pct;
   bit          hold_ask;
   int          stuck_cycles;

   fifo_block_pool_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) pool.match_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("fifo_block_pool_allocator_unit_tb: errors");
            $finish;
         end
      end
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_item(req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      pool.accept_request(it);
   endtask

   task automatic send_op(logic op, int cnt, int id);
      req_type it;
      it.operation = op;
      it.count     = 7'(cnt);
      it.block_id  = 6'(id);
      send_item(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pool.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_block_size(logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool.set_block_size(v);
   endtask

   function automatic req_type random_item();
      req_type it;
      int      live_ids[$];
      int      r;
      int      pick;
      it.operation = OP_REQUEST;
      it.count     = 7'($urandom_range(127));
      it.block_id  = 6'($urandom_range(63));
      for (int i = 0; i < POOL_DEPTH; i++)
         if (pool.live[i]) live_ids.push_front(i);
      r    = $urandom_range(99);
      pick = $urandom_range(99);
      if (r < 35) begin
         if (pick < 70)
            it.count = 7'($urandom_range(4, 1));
         else if (pick < 82)
            it.count = 7'($urandom_range(int'(pool.free_cnt), 0));
         else if (pick < 92)
            it.count = 7'($urandom_range(127, int'(pool.free_cnt) + 1));
         else
            it.count = '0;
      end else if (r < 92 && live_ids.size() > 0) begin
         it.operation = OP_RELEASE;
         it.block_id  = 6'(live_ids[$urandom_range(live_ids.size() - 1)]);
      end else begin
         it.operation = OP_RELEASE;
      end
      return it;
   endfunction

   // release-all, sent as single releases in random order
   task automatic release_all(inout int sent);
      int ids[$];
      int j;
      int t;
      for (int i = 0; i < POOL_DEPTH; i++)
         if (pool.live[i]) ids.push_front(i);
      for (int i = ids.size() - 1; i > 0; i--) begin
         j      = $urandom_range(i);
         t      = ids[i];
         ids[i] = ids[j];
         ids[j] = t;
      end
      foreach (ids[i]) begin
         send_op(OP_RELEASE, $urandom_range(127), ids[i]);
         sent++;
      end
   endtask

   task automatic run_phase(logic [15:0] bsize, int idle_pct, int stall, bit pressure);
      int sent;
      sent = 0;
      drain();
      write_block_size(bsize);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (pressure) begin
         hold_ask = 1'b1;
         send_op(OP_REQUEST, 12, 0);
      end
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(24) == 0) begin
            release_all(sent);
         end else begin
            send_item(random_item());
            sent++;
         end
      end
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_ask      = 1'b0;
      stuck_cycles  = 0;
      pool          = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pool edges, overflow counts, double release
      send_op(OP_RELEASE, 0, 5);
      send_op(OP_REQUEST, 0, 63);
      send_op(OP_REQUEST, 65, 0);
      send_op(OP_REQUEST, 127, 63);
      send_op(OP_REQUEST, 1, 0);
      send_op(OP_RELEASE, 127, 0);
      send_op(OP_RELEASE, 0, 0);
      send_op(OP_REQUEST, 64, 0);
      send_op(OP_REQUEST, 1, 0);
      send_op(OP_RELEASE, 0, 63);
      send_op(OP_RELEASE, 0, 0);
      send_op(OP_RELEASE, 0, 63);
      send_op(OP_REQUEST, 2, 0);
      send_op(OP_RELEASE, 0, 42);
      send_op(OP_RELEASE, 0, 21);
      send_op(OP_REQUEST, 3, 0);
      send_op(OP_REQUEST, 2, 0);
      send_op(OP_RELEASE, 0, 42);

      run_phase(16'hFFFF, 0, 0, 1'b1);
      run_phase(16'h0000, 77, 0, 1'b0);
      run_phase(16'h0001, 0, 77, 1'b0);
      run_phase(16'($urandom_range(65534, 2)), 23, 23, 1'b0);
      run_phase(BLOCK_SIZE_RESET, 0, 0, 1'b0);

      drain();
      repeat (10) @(posedge clock);
      if (pool.failures == 0 && pool.pending() == 0) begin
         $display("fifo_block_pool_allocator_unit_tb: clean");
      end else begin
         $display("fifo_block_pool_allocator_unit_tb: errors");
      end
      $finish;
   end
endmodule
